// File: design/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg - shared types and constants for the fixed slot pool allocator
// Request/result words, request kinds, status codes and default sizes.
// ----------------------------------------------------------------------------
package fspa_pkg;

    localparam int SLOT_COUNT       = 256;
    localparam int SLOT_W           = 8;
    localparam int COUNT_W          = 9;
    localparam int GROW_COUNT_DEF   = 16;
    localparam int MAX_BLOCKS_DEF   = 16;

    // request kinds
    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_FREE     = 2'd1;
    localparam logic [1:0] KIND_FREE_ALL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
    localparam logic [1:0] ST_NOT_IN_POOL = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0]  given_slot;
        logic [1:0]         status;
        logic [COUNT_W-1:0] live_count;
        logic [4:0]         blocks_in_use;
    } t_out_word;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] slot;
    } t_stack_cmd;

endpackage

// File: design/fspa_free_stack.sv
// ----------------------------------------------------------------------------
// fspa_free_stack - LIFO of freed slots, linked through a link memory
// Keeps the top and the entry below it in registers, and prefetches the
// link of the entry below so a pop needs no extra memory read.
// ----------------------------------------------------------------------------
module fspa_free_stack
    import fspa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stack_cmd        i_cmd,
    output logic [SLOT_W-1:0] o_top
);

    logic [SLOT_W-1:0] r_link_mem [SLOT_COUNT];
    logic [SLOT_W-1:0] r_top;
    logic [SLOT_W-1:0] n_top;
    logic [SLOT_W-1:0] r_below;
    logic [SLOT_W-1:0] n_below;
    logic [SLOT_W-1:0] r_below_link;

    // r_below_link always holds link[r_below]: it is read at the next
    // address of r_below. A push writes the new top, never the entry below.
    always_comb begin
        n_top   = r_top;
        n_below = r_below;
        if (i_cmd.push) begin
            n_top   = i_cmd.slot;
            n_below = r_top;
        end else if (i_cmd.pop) begin
            n_top   = r_below;
            n_below = r_below_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_below <= '0;
        end else begin
            r_top   <= n_top;
            r_below <= n_below;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_link_mem[i_cmd.slot] <= r_top;
        end
        r_below_link <= r_link_mem[n_below];
    end

    assign o_top = r_top;

endmodule

// File: design/fixed_slot_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_unit - fixed-size slot pool allocator
//
// Request channel (i_in_valid / o_in_ready / i_in_word): allocate, free one
// slot, or free all. Result channel (o_out_valid / i_out_ready /
// o_out_word): one word per request with the given slot, a status, the
// live slot count and the number of blocks grown.
// Allocation order: most recently freed slot first (LIFO), then untouched
// slots of the newest block in descending order, then a new block of
// GROW_COUNT slots, up to MAX_BLOCKS blocks within 256 slots.
// Result: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while the receiver does not stall; the
// free stack keeps the link of the entry below its top prefetched from the
// link memory, so a pop needs no extra memory read.
// Receiver stall: the result register holds its word; a new request is
// taken only when that register is empty or being drained in the same cycle.
// Reset: pool empty, no blocks grown, allocated map cleared. The link
// memory is not cleared; it is only read after it was written.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_unit
    import fspa_pkg::*;
#(
    parameter int GROW_COUNT = GROW_COUNT_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int BLK_FIT = SLOT_COUNT / GROW_COUNT;
    localparam int BLK_LIM = (MAX_BLOCKS < BLK_FIT) ? MAX_BLOCKS : BLK_FIT;
    localparam int BLK_W   = $clog2(BLK_LIM + 1);
    localparam int LEFT_W  = $clog2(GROW_COUNT + 1);

    logic                  r_stack_empty;
    logic                  n_stack_empty;
    logic [SLOT_W-1:0]     r_fresh_next;
    logic [SLOT_W-1:0]     n_fresh_next;
    logic [LEFT_W-1:0]     r_fresh_left;
    logic [LEFT_W-1:0]     n_fresh_left;
    logic [BLK_W-1:0]      r_blocks;
    logic [BLK_W-1:0]      n_blocks;
    logic [COUNT_W-1:0]    r_grown;
    logic [COUNT_W-1:0]    n_grown;
    logic [COUNT_W-1:0]    r_total;
    logic [COUNT_W-1:0]    n_total;
    logic [SLOT_COUNT-1:0] r_map;
    logic [SLOT_COUNT-1:0] n_map;
    logic                  r_out_valid;
    t_out_word             r_out_word;
    t_out_word             n_out_word;

    logic              take;
    t_stack_cmd        stack_cmd;
    logic [SLOT_W-1:0] stack_top;
    logic [COUNT_W:0]  busy_plus_one;
    logic [COUNT_W:0]  grown_new;
    logic [COUNT_W-1:0] blocks_wide;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign take       = i_in_valid && o_in_ready;

    fspa_free_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (stack_cmd),
        .o_top   (stack_top)
    );

    always_comb begin
        n_stack_empty = r_stack_empty;
        n_fresh_next  = r_fresh_next;
        n_fresh_left  = r_fresh_left;
        n_blocks      = r_blocks;
        n_grown       = r_grown;
        n_total       = r_total;
        n_map         = r_map;
        stack_cmd     = '{push: 1'b0, pop: 1'b0, slot: i_in_word.slot};
        n_out_word.given_slot = '0;
        n_out_word.status     = ST_OK;
        // free stack depth is grown - fresh_left - total
        busy_plus_one = (COUNT_W+1)'(r_fresh_left) + (COUNT_W+1)'(r_total)
                        + (COUNT_W+1)'(1);
        grown_new     = (COUNT_W+1)'(r_grown) + (COUNT_W+1)'(GROW_COUNT);

        if (take) begin
            case (i_in_word.kind)
                KIND_ALLOC: begin
                    if (!r_stack_empty) begin
                        stack_cmd.pop         = 1'b1;
                        n_out_word.given_slot = stack_top;
                        if ({1'b0, r_grown} <= busy_plus_one) begin
                            n_stack_empty = 1'b1;
                        end
                        n_map[stack_top] = 1'b1;
                        n_total          = r_total + COUNT_W'(1);
                    end else if (r_fresh_left != '0) begin
                        n_out_word.given_slot = r_fresh_next;
                        n_fresh_left          = r_fresh_left - LEFT_W'(1);
                        if (r_fresh_next != '0) begin
                            n_fresh_next = r_fresh_next - SLOT_W'(1);
                        end
                        n_map[r_fresh_next] = 1'b1;
                        n_total             = r_total + COUNT_W'(1);
                    end else if (r_blocks < BLK_W'(BLK_LIM)) begin
                        // grow: hand out the top slot of the new block
                        n_blocks              = r_blocks + BLK_W'(1);
                        n_grown               = grown_new[COUNT_W-1:0];
                        n_out_word.given_slot = SLOT_W'(grown_new - (COUNT_W+1)'(1));
                        n_fresh_left          = LEFT_W'(GROW_COUNT - 1);
                        n_fresh_next          = SLOT_W'(grown_new - (COUNT_W+1)'(1));
                        if (n_out_word.given_slot != '0) begin
                            n_fresh_next = n_out_word.given_slot - SLOT_W'(1);
                        end
                        n_map[n_out_word.given_slot] = 1'b1;
                        n_total                      = r_total + COUNT_W'(1);
                    end else begin
                        n_out_word.status = ST_EXHAUSTED;
                    end
                end
                KIND_FREE: begin
                    if ({1'b0, i_in_word.slot} >= r_grown) begin
                        n_out_word.status = ST_NOT_IN_POOL;
                    end else if (!r_map[i_in_word.slot]) begin
                        n_out_word.status = ST_NOT_ALLOC;
                    end else begin
                        n_map[i_in_word.slot] = 1'b0;
                        n_total               = r_total - COUNT_W'(1);
                        stack_cmd.push        = 1'b1;
                        n_stack_empty         = 1'b0;
                    end
                end
                KIND_FREE_ALL: begin
                    n_stack_empty = 1'b1;
                    n_fresh_next  = '0;
                    n_fresh_left  = '0;
                    n_blocks      = '0;
                    n_grown       = '0;
                    n_total       = '0;
                    n_map         = '0;
                end
                default: begin
                end
            endcase
        end

        blocks_wide                 = COUNT_W'(n_blocks);
        n_out_word.live_count       = n_total;
        n_out_word.blocks_in_use    = blocks_wide[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_empty <= 1'b1;
            r_fresh_next  <= '0;
            r_fresh_left  <= '0;
            r_blocks      <= '0;
            r_grown       <= '0;
            r_total       <= '0;
            r_map         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_stack_empty <= n_stack_empty;
            r_fresh_next  <= n_fresh_next;
            r_fresh_left  <= n_fresh_left;
            r_blocks      <= n_blocks;
            r_grown       <= n_grown;
            r_total       <= n_total;
            r_map         <= n_map;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// File: design/fspa_checker.sv
// ----------------------------------------------------------------------------
// fspa_checker - port-level checks for the slot pool allocator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module fspa_checker
    import fspa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fail_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.given_slot == '0)
        else $error("failed request returned a slot");

    a_free_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.kind == KIND_FREE_ALL |=>
        o_out_valid && o_out_word.live_count == '0 &&
        o_out_word.blocks_in_use == '0 && o_out_word.status == ST_OK)
        else $error("free all did not empty the pool");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (.*);

// File: verif/tb_fixed_slot_pool_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_slot_pool_allocator_unit - testbench for the fixed slot pool allocator
// A table of directed requests runs first, then a fill of the whole pool
// into exhaustion; random bursts of allocate and free traffic follow. Every
// result word is compared field by field against a behavioral pool model,
// or against the table's word for typed rows. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_fixed_slot_pool_allocator_unit;
    import fspa_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int GROW = GROW_COUNT_DEF;
    localparam int MAXB = MAX_BLOCKS_DEF;
    localparam int RAND_ITEMS = 600;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    fixed_slot_pool_allocator_unit #(
        .GROW_COUNT(GROW),
        .MAX_BLOCKS(MAXB)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // pool model state
    logic [SLOT_W-1:0] link_mem [SLOT_COUNT] = '{default: '0};
    logic [SLOT_W-1:0] top_slot;
    bit                stack_none;
    int                fresh_slot;
    int                fresh_cnt;
    int                blocks_cnt;
    int                live_cnt;
    bit                in_use [SLOT_COUNT];

    t_out_word pending_results [$];
    t_out_word oldest;
    int        err_cnt = 0;
    int        checked_cnt = 0;
    int        status_cnt [4] = '{default: 0};
    bit        no_gaps = 1'b0;

    typedef struct {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  slot;
        bit                 typed;
        logic [SLOT_W-1:0]  want_slot;
        logic [1:0]         want_status;
        logic [COUNT_W-1:0] want_live;
        logic [4:0]         want_blocks;
    } t_req_row;

    // typed rows carry the expected word; the rest go through the model
    t_req_row dir_tab [17] = '{
        '{KIND_ALLOC,    8'h00, 1'b1, 8'd15, ST_OK,          9'd1, 5'd1},
        '{KIND_ALLOC,    8'h00, 1'b1, 8'd14, ST_OK,          9'd2, 5'd1},
        '{KIND_FREE,     8'd16, 1'b1, 8'd0,  ST_NOT_IN_POOL, 9'd2, 5'd1},
        '{KIND_FREE,     8'hFF, 1'b1, 8'd0,  ST_NOT_IN_POOL, 9'd2, 5'd1},
        '{KIND_FREE,     8'd0,  1'b1, 8'd0,  ST_NOT_ALLOC,   9'd2, 5'd1},
        '{KIND_FREE,     8'd15, 1'b1, 8'd0,  ST_OK,          9'd1, 5'd1},
        '{KIND_FREE,     8'd15, 1'b1, 8'd0,  ST_NOT_ALLOC,   9'd1, 5'd1},
        '{KIND_FREE,     8'd14, 1'b1, 8'd0,  ST_OK,          9'd0, 5'd1},
        '{KIND_ALLOC,    8'h00, 1'b1, 8'd14, ST_OK,          9'd1, 5'd1},
        '{KIND_ALLOC,    8'h00, 1'b1, 8'd15, ST_OK,          9'd2, 5'd1},
        '{KIND_ALLOC,    8'h00, 1'b1, 8'd13, ST_OK,          9'd3, 5'd1},
        '{KIND_UNUSED,   8'hAA, 1'b1, 8'd0,  ST_OK,          9'd3, 5'd1},
        '{KIND_FREE_ALL, 8'h55, 1'b1, 8'd0,  ST_OK,          9'd0, 5'd0},
        '{KIND_FREE,     8'd0,  1'b1, 8'd0,  ST_NOT_IN_POOL, 9'd0, 5'd0},
        '{KIND_ALLOC,    8'hFF, 1'b1, 8'd15, ST_OK,          9'd1, 5'd1},
        '{KIND_FREE,     8'd15, 1'b0, 8'd0,  ST_OK,          9'd0, 5'd0},
        '{KIND_ALLOC,    8'h7F, 1'b0, 8'd0,  ST_OK,          9'd0, 5'd0}
    };

    function automatic void pool_clear();
        foreach (in_use[s]) in_use[s] = 1'b0;
        top_slot = '0;
        stack_none = 1'b1;
        fresh_slot = 0;
        fresh_cnt = 0;
        blocks_cnt = 0;
        live_cnt = 0;
    endfunction

    function automatic t_out_word pool_predict(t_in_word w);
        t_out_word res;
        int        depth;
        res = '0;
        res.status = ST_OK;
        case (w.kind)
            KIND_ALLOC: begin
                if (!stack_none) begin
                    // free stack depth is implied by the counters
                    depth = blocks_cnt * GROW - fresh_cnt - live_cnt;
                    res.given_slot = top_slot;
                    top_slot = link_mem[top_slot];
                    if (depth <= 1) stack_none = 1'b1;
                end else begin
                    if (fresh_cnt == 0 && blocks_cnt < MAXB &&
                        (blocks_cnt + 1) * GROW <= SLOT_COUNT) begin
                        blocks_cnt++;
                        fresh_cnt = GROW;
                        fresh_slot = blocks_cnt * GROW - 1;
                    end
                    if (fresh_cnt != 0) begin
                        res.given_slot = SLOT_W'(fresh_slot);
                        fresh_cnt--;
                        if (fresh_slot != 0) fresh_slot--;
                    end else begin
                        res.status = ST_EXHAUSTED;
                    end
                end
                if (res.status == ST_OK) begin
                    in_use[res.given_slot] = 1'b1;
                    live_cnt++;
                end
            end
            KIND_FREE: begin
                if (int'(w.slot) >= blocks_cnt * GROW) begin
                    res.status = ST_NOT_IN_POOL;
                end else if (!in_use[w.slot]) begin
                    res.status = ST_NOT_ALLOC;
                end else begin
                    in_use[w.slot] = 1'b0;
                    if (live_cnt != 0) live_cnt--;
                    link_mem[w.slot] = top_slot;
                    top_slot = w.slot;
                    stack_none = 1'b0;
                end
            end
            KIND_FREE_ALL: pool_clear();
            default: ;
        endcase
        res.live_count = COUNT_W'(live_cnt);
        res.blocks_in_use = 5'(blocks_cnt);
        return res;
    endfunction

    task automatic send_req(input t_in_word w, input bit typed = 1'b0,
                            input t_out_word want = '0);
        t_out_word res;
        while (!no_gaps && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        res = pool_predict(w);
        if (typed) res = want;
        pending_results.push_back(res);
        status_cnt[res.status]++;
    endtask

    // hold off the request side until every result word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word %h with nothing pending", o_out_word);
                err_cnt++;
            end else begin
                oldest = pending_results.pop_front();
                checked_cnt++;
                if (o_out_word.given_slot !== oldest.given_slot) begin
                    $error("given_slot: expected %0d, got %0d",
                           oldest.given_slot, o_out_word.given_slot);
                    err_cnt++;
                end
                if (o_out_word.status !== oldest.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest.status, o_out_word.status);
                    err_cnt++;
                end
                if (o_out_word.live_count !== oldest.live_count) begin
                    $error("live_count: expected %0d, got %0d",
                           oldest.live_count, o_out_word.live_count);
                    err_cnt++;
                end
                if (o_out_word.blocks_in_use !== oldest.blocks_in_use) begin
                    $error("blocks_in_use: expected %0d, got %0d",
                           oldest.blocks_in_use, o_out_word.blocks_in_use);
                    err_cnt++;
                end
            end
        end
        i_out_ready <= no_gaps || ($urandom_range(99) >= 33);
    end

    initial begin : stimulus
        t_in_word w;
        int       rand_items;
        int       phase_no;
        int       alloc_pct;
        int       burst;
        int       r;
        int       k;
        pool_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_req({dir_tab[i].kind, dir_tab[i].slot}, dir_tab[i].typed,
                     {dir_tab[i].want_slot, dir_tab[i].want_status,
                      dir_tab[i].want_live, dir_tab[i].want_blocks});
        end

        // fill every block and run past the end of the pool
        send_req({KIND_FREE_ALL, 8'($urandom)});
        repeat (SLOT_COUNT + 4) send_req({KIND_ALLOC, 8'($urandom)});
        rand_items = SLOT_COUNT + 5;
        wait_drained();

        phase_no = 0;
        while (rand_items < RAND_ITEMS) begin
            no_gaps <= (phase_no >= 3 && phase_no <= 5);
            if ($urandom_range(4) == 0) begin
                send_req({KIND_FREE_ALL, 8'($urandom)});
                rand_items++;
            end
            alloc_pct = $urandom_range(25, 80);
            burst = $urandom_range(15, 50);
            repeat (burst) begin
                r = $urandom_range(99);
                w.slot = 8'($urandom);
                if (r < alloc_pct) begin
                    w.kind = KIND_ALLOC;
                end else if (r < 93) begin
                    w.kind = KIND_FREE;
                    if (live_cnt != 0) begin
                        // pick one of the slots currently handed out
                        k = $urandom_range(live_cnt - 1);
                        for (int s = 0; s < SLOT_COUNT; s++) begin
                            if (in_use[s]) begin
                                if (k == 0) w.slot = 8'(s);
                                k--;
                            end
                        end
                    end
                end else if (r < 97) begin
                    w.kind = KIND_FREE;
                end else if (r < 99) begin
                    w.kind = KIND_UNUSED;
                end else begin
                    w.kind = KIND_FREE_ALL;
                end
                send_req(w);
                if (w.kind != KIND_UNUSED) rand_items++;
            end
            if ($urandom_range(3) == 0) wait_drained();
            phase_no++;
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("%0d words checked: %0d ok, %0d exhausted, %0d outside pool, %0d not allocated",
                 checked_cnt, status_cnt[ST_OK], status_cnt[ST_EXHAUSTED],
                 status_cnt[ST_NOT_IN_POOL], status_cnt[ST_NOT_ALLOC]);
        $display("directed table of %0d rows, full-pool fill, %0d random bursts",
                 $size(dir_tab), phase_no);
        if (err_cnt == 0) begin
            $display("tb_fixed_slot_pool_allocator_unit passed");
        end else begin
            $display("tb_fixed_slot_pool_allocator_unit failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400_000);
        $display("tb_fixed_slot_pool_allocator_unit failed");
        $finish;
    end

endmodule
